FILE: rtl/core/ktsr_pkg.sv
// shared types, codes and defaults for the keyed table with swap remove
`timescale 1ns / 1ps

package ktsr_pkg;

  // default sizes
  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_KEY_WIDTH  = 32;
  localparam int DEF_DATA_WIDTH = 32;

  // command codes
  typedef logic [1:0] ktsr_cmd_t;
  localparam ktsr_cmd_t CMD_APPEND = 2'd0;
  localparam ktsr_cmd_t CMD_LOOKUP = 2'd1;
  localparam ktsr_cmd_t CMD_REMOVE = 2'd2;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } ktsr_status_t;

  // input beat
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key;
    logic [31:0] write_data;
  } ktsr_in_t;

  // result beat
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_data;
    logic [4:0]  entry_count;
    logic        is_empty;
  } ktsr_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic         capture;
    logic         wr_append;
    logic         rd_start;
    logic         rd_next;
    logic         rd_last;
    logic         mark_slot;
    logic         wr_move;
    logic         set_status;
    ktsr_status_t status;
    logic         load_rdata;
    logic         load_out;
  } ktsr_ctl_t;

  // datapath to controller status
  typedef struct packed {
    ktsr_cmd_t cmd;
    logic      full;
    logic      empty;
    logic      match;
    logic      scan_last;
  } ktsr_sts_t;

endpackage

FILE: rtl/core/ktsr_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module ktsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/ktsr_datapath.sv
// table datapath: key and data memories, entry count, scan index and result registers
`timescale 1ns / 1ps

module ktsr_datapath
  import ktsr_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int KEY_WIDTH  = DEF_KEY_WIDTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ktsr_in_t  in_data,
  input  ktsr_ctl_t ctl,
  output ktsr_sts_t sts,
  output ktsr_out_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         idx_r;
  logic [AW-1:0]         slot_r;
  ktsr_cmd_t             cmd_r;
  logic [KEY_WIDTH-1:0]  key_r;
  logic [DATA_WIDTH-1:0] data_r;
  ktsr_status_t          status_r;
  logic [31:0]           rdata_r;
  ktsr_out_t             out_r;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [KEY_WIDTH-1:0]  key_wdata, key_rd;
  logic [DATA_WIDTH-1:0] data_wdata, data_rd;
  logic                  rd_any;

  // memory write side: append at the end or move the last entry into the hole
  assign ram_we     = ctl.wr_append | ctl.wr_move;
  assign ram_waddr  = ctl.wr_append ? AW'(count_r) : slot_r;
  assign key_wdata  = ctl.wr_append ? key_r  : key_rd;
  assign data_wdata = ctl.wr_append ? data_r : data_rd;

  // memory read address: first slot, next slot or last occupied slot
  assign rd_any = ctl.rd_start | ctl.rd_next | ctl.rd_last;
  always_comb begin
    ram_raddr = idx_r;
    if (ctl.rd_start) begin
      ram_raddr = '0;
    end else if (ctl.rd_next) begin
      ram_raddr = AW'(idx_r + 1'b1);
    end else if (ctl.rd_last) begin
      ram_raddr = AW'(count_r - 1'b1);
    end
  end

  ktsr_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key_wdata),
    .raddr (ram_raddr),
    .rdata (key_rd)
  );

  ktsr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_data_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (data_wdata),
    .raddr (ram_raddr),
    .rdata (data_rd)
  );

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (ctl.wr_append) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (ctl.wr_move) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // captured item, scan index, slot and result
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r    <= in_data.command;
      key_r    <= KEY_WIDTH'(in_data.key);
      data_r   <= DATA_WIDTH'(in_data.write_data);
      status_r <= ST_DONE;
      rdata_r  <= '0;
    end
    if (rd_any) begin
      idx_r <= ram_raddr;
    end
    if (ctl.mark_slot) begin
      slot_r <= idx_r;
    end
    if (ctl.set_status) begin
      status_r <= ctl.status;
    end
    if (ctl.load_rdata) begin
      rdata_r <= 32'(data_rd);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_r.status      <= status_r;
      out_r.read_data   <= rdata_r;
      out_r.entry_count <= 5'(count_r);
      out_r.is_empty    <= (count_r == '0);
    end
  end

  assign out_data = out_r;

  // status towards the controller
  assign sts.cmd       = cmd_r;
  assign sts.full      = (count_r >= CW'(CAPACITY));
  assign sts.empty     = (count_r == '0);
  assign sts.match     = (key_rd == key_r);
  assign sts.scan_last = ((CW'(idx_r) + CW'(1)) == count_r);

  // count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a move always shrinks the table by one
  a_move_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_move |=> count_r == CW'($past(count_r) - 1'b1))
    else $error("move did not drop the count");

endmodule

FILE: rtl/core/ktsr_ctrl.sv
// sequencing state machine and result handshake for the keyed table
`timescale 1ns / 1ps

module ktsr_ctrl
  import ktsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ktsr_sts_t sts,
  output ktsr_ctl_t ctl
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_SCAN = 5'b00100,
    S_MOVE = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  logic   out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // next state and datapath commands
  always_comb begin
    state_nxt  = state_r;
    ctl        = '0;
    ctl.status = ST_DONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ctl.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        case (sts.cmd) inside
          CMD_APPEND: begin
            if (sts.full) begin
              ctl.set_status = 1'b1;
              ctl.status     = ST_FULL;
            end else begin
              ctl.wr_append = 1'b1;
            end
          end
          CMD_LOOKUP, CMD_REMOVE: begin
            if (sts.empty) begin
              ctl.set_status = 1'b1;
              ctl.status     = ST_NOT_FOUND;
            end else begin
              ctl.rd_start = 1'b1;
              state_nxt    = S_SCAN;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (sts.match) begin
          if (sts.cmd == CMD_LOOKUP) begin
            ctl.load_rdata = 1'b1;
            state_nxt      = S_RESP;
          end else begin
            ctl.mark_slot = 1'b1;
            ctl.rd_last   = 1'b1;
            state_nxt     = S_MOVE;
          end
        end else if (sts.scan_last) begin
          ctl.set_status = 1'b1;
          ctl.status     = ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end else begin
          ctl.rd_next = 1'b1;
        end
      end
      S_MOVE: begin
        ctl.wr_move = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // an accepted beat always goes to execution next
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_EXEC)
    else $error("accepted beat not executed");

  // a new result only comes out of the response state
  a_valid_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside response state");

  // a lookup hit goes straight to the response
  a_lookup_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.match && sts.cmd == CMD_LOOKUP) |=> state_r == S_RESP)
    else $error("lookup hit did not respond");

  // a pending result is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !ctl.load_out)
    else $error("stalled result overwritten");

endmodule

FILE: rtl/core/keyed_table_swap_remove_top.sv
// top level of the keyed table with append, lookup and swap remove
// flow: accept, execute, then response for an append, a dropped append or an unused
//   command; lookup and remove first scan the keys from slot 0, one slot per cycle, and
//   a remove hit moves the last entry into the hole before the response
// one item at a time; the next waits until the result is loaded, after any result stall
// reset: synchronous; entry count and control cleared; memories are not cleared
`timescale 1ns / 1ps

module keyed_table_swap_remove_top
  import ktsr_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int KEY_WIDTH  = DEF_KEY_WIDTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ktsr_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ktsr_out_t out_data
);

  ktsr_ctl_t ctl;
  ktsr_sts_t sts;

  // sequencer
  ktsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // storage and result datapath
  ktsr_datapath #(
    .CAPACITY   (CAPACITY),
    .KEY_WIDTH  (KEY_WIDTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .ctl      (ctl),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

FILE: dv/ktsr_table_checker.sv
// checker for the keyed table: mirrors the table and compares every result beat
`timescale 1ns / 1ps

module ktsr_table_checker
  import ktsr_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  ktsr_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  ktsr_out_t out_data,
  output int        fail_count,
  output int        pending
);

  // mirror of the table contents
  logic [31:0] table_keys [CAPACITY];
  logic [31:0] table_data [CAPACITY];
  int          table_count;

  // results still owed by the block, oldest first
  ktsr_out_t   owed_results [$];
  int          reported;

  // apply one command to the mirror and give the result it should produce
  function automatic ktsr_out_t apply_command(ktsr_in_t beat);
    ktsr_out_t res;
    int        slot;
    res        = '0;
    res.status = ST_DONE;
    slot       = -1;
    // lowest occupied slot holding the key
    for (int i = 0; i < table_count; i++) begin
      if (slot < 0 && table_keys[i] == beat.key) slot = i;
    end
    case (beat.command)
      CMD_APPEND: begin
        if (table_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          table_keys[table_count] = beat.key;
          table_data[table_count] = beat.write_data;
          table_count++;
        end
      end
      CMD_LOOKUP: begin
        if (slot < 0) res.status = ST_NOT_FOUND;
        else res.read_data = table_data[slot];
      end
      CMD_REMOVE: begin
        if (slot < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          // last entry fills the hole
          table_count--;
          table_keys[slot] = table_keys[table_count];
          table_data[slot] = table_data[table_count];
        end
      end
      default: ;
    endcase
    res.entry_count = 5'(table_count);
    res.is_empty    = (table_count == 0);
    return res;
  endfunction

  // compare one field, report only the first few mismatches
  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      reported++;
      if (reported <= 10)
        $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, field, want, got);
    end
  endfunction

  // watch both channels at the rising edge
  always @(posedge clk) begin : watch
    ktsr_out_t want;
    if (!rst_n) begin
      table_count = 0;
      owed_results.delete();
      fail_count  = 0;
      reported    = 0;
      pending    <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          fail_count++;
          reported++;
          if (reported <= 10)
            $display("%0t: result beat with nothing owed, actual %0h", $realtime, out_data);
        end else begin
          want = owed_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("read_data", want.read_data, out_data.read_data);
          check_field("entry_count", 32'(want.entry_count), 32'(out_data.entry_count));
          check_field("is_empty", 32'(want.is_empty), 32'(out_data.is_empty));
        end
      end
      if (in_valid && !in_stall) owed_results.push_back(apply_command(in_data));
      pending <= owed_results.size();
    end
  end

endmodule

FILE: dv/tb.sv
// testbench top: drives commands into the keyed table and gives the verdict
`timescale 1ns / 1ps

module tb;
  import ktsr_pkg::*;

  localparam int        CAPACITY   = DEF_CAPACITY;
  localparam int        PHASE_LEN  = 475;
  localparam int        BURST_LEN  = 25;
  localparam ktsr_cmd_t CMD_UNUSED = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  ktsr_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ktsr_out_t out_data;
  int        fail_count;
  int        pending;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  logic [31:0] key_pool [6];

  keyed_table_swap_remove_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ktsr_table_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  // result side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // one input beat, with random gaps before it
  task automatic send_beat(ktsr_cmd_t cmd, logic [31:0] key, logic [31:0] wdata);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid           = 1'b1;
    in_data.command    = cmd;
    in_data.key        = key;
    in_data.write_data = wdata;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the sender off until every owed result has come back
  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
  endtask

  // a burst over a small key pool so that lookups and removes mostly hit
  task automatic random_burst(int n);
    int        append_pct;
    int        r;
    ktsr_cmd_t cmd;
    logic [31:0] key;
    case ($urandom_range(0, 2))
      0:       append_pct = 15;
      1:       append_pct = 50;
      default: append_pct = 85;
    endcase
    foreach (key_pool[i]) begin
      case ($urandom_range(0, 3))
        0:       key_pool[i] = 32'h1 << $urandom_range(0, 31);
        1:       key_pool[i] = ~(32'h1 << $urandom_range(0, 31));
        default: key_pool[i] = $urandom;
      endcase
    end
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < 3) cmd = CMD_UNUSED;
      else if (r < 3 + append_pct * 97 / 100) cmd = CMD_APPEND;
      else if ($urandom_range(0, 1) == 0) cmd = CMD_LOOKUP;
      else cmd = CMD_REMOVE;
      if ($urandom_range(0, 99) < 88) key = key_pool[$urandom_range(0, 5)];
      else key = $urandom;
      send_beat(cmd, key, $urandom);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, duplicates, first match, swap remove, full table
    send_beat(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_beat(CMD_REMOVE, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(CMD_APPEND, 32'h0000_0000, 32'hffff_ffff);
    send_beat(CMD_APPEND, 32'hffff_ffff, 32'h0000_0000);
    send_beat(CMD_APPEND, 32'h0000_0000, 32'h1234_5678);
    send_beat(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_beat(CMD_LOOKUP, 32'ha5a5_a5a5, 32'h0000_0000);
    send_beat(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_beat(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    // the removed entry sits in the last occupied slot
    send_beat(CMD_REMOVE, 32'hffff_ffff, 32'h0000_0000);
    for (int i = 1; i < CAPACITY; i++)
      send_beat(CMD_APPEND, 32'h8000_0000 ^ i, ~i);
    send_beat(CMD_APPEND, 32'h5a5a_5a5a, 32'hc3c3_c3c3);
    send_beat(CMD_UNUSED, 32'h0000_0000, 32'h0000_0000);
    drain();

    // random phases with different idling and result stalling
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      for (int b = 0; b < PHASE_LEN / BURST_LEN; b++) begin
        random_burst(BURST_LEN);
        if (b == 9) drain();
      end
      drain();
    end

    repeat (CAPACITY + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[keyed_table_swap_remove_top] OK");
    else
      $display("[keyed_table_swap_remove_top] ERROR");
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("[keyed_table_swap_remove_top] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ktsr_pkg.sv
rtl/core/ktsr_ram.sv
rtl/core/ktsr_datapath.sv
rtl/core/ktsr_ctrl.sv
rtl/core/keyed_table_swap_remove_top.sv
dv/ktsr_table_checker.sv
dv/tb.sv
